FILE: rtl/matrix_transform_engine_defines.svh
// Assertion macros shared by the checker of the matrix transform engine.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef MATRIX_TRANSFORM_ENGINE_DEFINES_SVH
`define MATRIX_TRANSFORM_ENGINE_DEFINES_SVH
`define MTE_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define MTE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: rtl/mte_pkg.sv
// Types and constants of the matrix transform engine.
// No dependencies.
package mte_pkg;
    typedef enum logic [2:0] {
        FN_XFORM = 3'd0, FN_LOAD = 3'd1, FN_IDENT = 3'd2, FN_SCALE = 3'd3,
        FN_TRANS = 3'd4, FN_ROTX = 3'd5, FN_ROTY = 3'd6, FN_ROTZ = 3'd7
    } t_func;

    localparam logic signed [31:0] ANG_PI      = 32'sd843314857;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int unsigned        TRIG_FRAC   = 30;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0: r = 32'sd210828714;
            5'd1: r = 32'sd124459457;
            5'd2: r = 32'sd65760959;
            5'd3: r = 32'sd33381290;
            5'd4: r = 32'sd16755422;
            5'd5: r = 32'sd8385879;
            5'd6: r = 32'sd4193963;
            5'd7: r = 32'sd2097109;
            5'd8: r = 32'sd1048571;
            5'd9: r = 32'sd524287;
            default: r = (i < 5'd28) ? (32'sd1 <<< (5'd28 - i)) : 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -64'sh0000000080000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic sat_hit(input logic signed [63:0] v);
        return (v > 64'sh000000007FFFFFFF) || (v < -64'sh0000000080000000);
    endfunction
endpackage

FILE: rtl/matrix_transform_engine.sv
// Matrix transform engine: a 4x4 Q16.16 matrix in a 16-entry memory with a registered read,
// reset to identity by a write pass over all 16 entries during which o_ready stays low. One
// item is worked on at a time, one matrix element per step. Transform and scale pass through
// S_RD and S_CALC per element, translate through S_RD, S_RD2 and S_CALC, load and identity go
// straight to S_DONE, and rotations run the CORDIC one iteration a cycle, then S_RD, S_RD2 and
// two S_CALC phases per column of the two rows. The result is presented from S_DONE, which
// returns to idle so the next item can be taken, except after identity, which first reruns the
// write pass. The result sits in an output register, so a stalled result holds up only the
// completion of the following item.
module matrix_transform_engine
    import mte_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_elem_index,
    input  logic signed [31:0] i_comp_x,
    input  logic signed [31:0] i_comp_y,
    input  logic signed [31:0] i_comp_z,
    input  logic signed [31:0] i_comp_w,
    input  logic signed [30:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_saturated
);
    typedef enum logic [2:0] {
        S_IDLE, S_TRIG, S_RD, S_RD2, S_CALC, S_DONE
    } t_state;

    localparam logic signed [31:0] ONE       = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF_LSB  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] HALF_TRIG = 68'sd1 <<< (TRIG_FRAC - 1);

    t_state             r_state;
    t_func              r_func;
    logic [3:0]         r_idx;
    logic signed [31:0] r_v [4];
    logic [1:0]         r_row, r_col;
    logic [4:0]         r_sweep;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_a, r_t;
    logic               r_phase;
    logic               r_sat;
    logic signed [33:0] r_s, r_c;
    logic signed [31:0] r_res [4];

    logic signed [31:0] mem [16];
    logic signed [31:0] r_rd;
    logic [3:0]         rd_addr;
    logic               we;
    logic [3:0]         wr_addr;
    logic signed [31:0] wr_data;

    logic               cor_start, cor_done;
    logic signed [33:0] cor_sin, cor_cos;
    logic [1:0]         prow, qrow;

    logic signed [31:0] mula, mulb;
    logic signed [63:0] prod, rp, sum;
    logic signed [67:0] ta, tb;
    logic signed [35:0] ra, rb, rot_val;

    mte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_angle(i_angle),
        .o_done(cor_done), .o_sin(cor_sin), .o_cos(cor_cos)
    );

    always_comb begin
        unique case (r_func)
            FN_ROTX: begin prow = 2'd1; qrow = 2'd2; end
            FN_ROTY: begin prow = 2'd2; qrow = 2'd0; end
            default: begin prow = 2'd0; qrow = 2'd1; end
        endcase
    end

    assign o_ready   = (r_state == S_IDLE) && r_sweep[4];
    assign cor_start = o_ready && i_valid && (i_func >= 3'(FN_ROTX));

    // Translate reads row 3 first, then the target element; rotations read p, then q.
    always_comb begin
        rd_addr = {r_row, r_col};
        if (r_func == FN_TRANS) begin
            rd_addr = (r_state == S_RD) ? {2'd3, r_col} : {r_row, r_col};
        end else if (r_func >= FN_ROTX) begin
            rd_addr = (r_state == S_RD) ? {prow, r_col} : {qrow, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // Rotation: r_t holds the p element and r_a the q element, giving c*p - s*q in
    // phase 0 and s*p + c*q in phase 1.
    always_comb begin
        mula = (r_func == FN_TRANS) ? r_t : r_rd;
        mulb = (r_func == FN_XFORM) ? r_v[r_col] : r_v[r_row];
        prod = 64'(mula) * 64'(mulb);
        rp   = (prod + HALF_LSB) >>> FRAC_BITS;
        if (r_func == FN_TRANS) sum = 64'(r_rd) + rp;
        else if (r_func == FN_XFORM) sum = r_acc + rp;
        else sum = rp;
        ta = 68'(r_phase ? r_s : r_c) * 68'(r_t);
        tb = 68'(r_phase ? r_c : r_s) * 68'(r_phase ? r_a : r_rd);
        ra = 36'((ta + HALF_TRIG) >>> TRIG_FRAC);
        rb = 36'((tb + HALF_TRIG) >>> TRIG_FRAC);
        rot_val = r_phase ? (ra + rb) : (ra - rb);
    end

    always_comb begin
        we = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (r_state == S_IDLE && !r_sweep[4]) begin
            we = 1'b1;
            wr_addr = r_sweep[3:0];
            wr_data = (r_sweep[1:0] == r_sweep[3:2]) ? ONE : 32'sd0;
        end else if (r_state == S_DONE && r_func == FN_LOAD) begin
            we = 1'b1;
            wr_addr = r_idx;
            wr_data = r_v[0];
        end else if (r_state == S_CALC) begin
            unique case (r_func)
                FN_SCALE, FN_TRANS: begin
                    we = 1'b1;
                    wr_addr = {r_row, r_col};
                    wr_data = sat32(sum);
                end
                FN_ROTX, FN_ROTY, FN_ROTZ: begin
                    we = 1'b1;
                    wr_addr = r_phase ? {qrow, r_col} : {prow, r_col};
                    wr_data = sat32(64'(rot_val));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FN_XFORM;
            o_valid <= 1'b0;
            r_sweep <= '0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) o_valid <= 1'b0;
            if (!r_sweep[4] && r_state == S_IDLE) r_sweep <= r_sweep + 1'b1;
            unique case (r_state)
                S_IDLE: if (o_ready && i_valid) begin
                    r_func <= t_func'(i_func);
                    r_idx  <= i_elem_index;
                    r_v[0] <= i_comp_x; r_v[1] <= i_comp_y;
                    r_v[2] <= i_comp_z; r_v[3] <= i_comp_w;
                    r_row <= '0; r_col <= '0; r_sat <= 1'b0; r_acc <= '0;
                    r_phase <= 1'b0;
                    for (int k = 0; k < 4; k++) r_res[k] <= '0;
                    unique case (t_func'(i_func))
                        FN_LOAD: r_state <= S_DONE;
                        FN_IDENT: begin
                            r_sweep <= '0;
                            r_state <= S_DONE;
                        end
                        FN_ROTX, FN_ROTY, FN_ROTZ: r_state <= S_TRIG;
                        default: r_state <= S_RD;
                    endcase
                end
                S_TRIG: if (cor_done) begin
                    r_s <= cor_sin; r_c <= cor_cos; r_state <= S_RD;
                end
                S_RD: r_state <= (r_func == FN_XFORM || r_func == FN_SCALE) ? S_CALC : S_RD2;
                S_RD2: begin
                    r_t <= r_rd;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    unique case (r_func)
                        FN_XFORM: begin
                            if (r_col == 2'd3) begin
                                r_res[r_row] <= sat32(sum);
                                r_sat <= r_sat | sat_hit(sum);
                                r_acc <= '0;
                                r_row <= r_row + 1'b1;
                                r_state <= (r_row == 2'd3) ? S_DONE : S_RD;
                            end else begin
                                r_acc <= sum;
                                r_state <= S_RD;
                            end
                            r_col <= r_col + 1'b1;
                        end
                        FN_SCALE, FN_TRANS: begin
                            r_sat <= r_sat | sat_hit(sum);
                            r_col <= r_col + 1'b1;
                            if (r_col == 2'd3) r_row <= r_row + 1'b1;
                            r_state <= (r_col == 2'd3 && r_row == 2'd2) ? S_DONE : S_RD;
                        end
                        default: begin
                            r_sat <= r_sat | sat_hit(64'(rot_val));
                            r_phase <= ~r_phase;
                            if (r_phase) begin
                                r_col <= r_col + 1'b1;
                                r_state <= (r_col == 2'd3) ? S_DONE : S_RD;
                            end else begin
                                r_a <= r_rd;
                            end
                        end
                    endcase
                end
                S_DONE: if (!o_valid || i_ready) begin
                    o_valid     <= 1'b1;
                    o_out_x     <= r_res[0];
                    o_out_y     <= r_res[1];
                    o_out_z     <= r_res[2];
                    o_out_w     <= r_res[3];
                    o_saturated <= r_sat;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/mte_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine in Q4.30, one step a cycle.
// Depends on mte_pkg.
module mte_cordic
    import mte_pkg::*;
#(
    parameter int STEPS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [30:0] i_angle,
    output logic               o_done,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);
    localparam int CW = $clog2(STEPS + 1);

    logic               r_busy;
    logic [CW-1:0]      r_cnt;
    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_a;
    logic               r_neg;
    logic signed [31:0] a0;
    logic [4:0]         idx;

    assign idx = 5'(r_cnt);

    always_comb begin
        a0 = 32'(i_angle);
        if (a0 > ANG_HALF_PI) a0 = a0 - ANG_PI;
        else if (a0 < -ANG_HALF_PI) a0 = a0 + ANG_PI;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_a    <= a0;
                r_neg  <= (32'(i_angle) > ANG_HALF_PI) || (32'(i_angle) < -ANG_HALF_PI);
            end else if (r_busy) begin
                if (r_a >= 0) begin
                    r_x <= r_x - (r_y >>> idx);
                    r_y <= r_y + (r_x >>> idx);
                    r_a <= r_a - atan_entry(idx);
                end else begin
                    r_x <= r_x + (r_y >>> idx);
                    r_y <= r_y - (r_x >>> idx);
                    r_a <= r_a + atan_entry(idx);
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_sin = r_neg ? -r_y : r_y;
    assign o_cos = r_neg ? -r_x : r_x;
endmodule

FILE: rtl/mte_checker.sv
// Port-level checker for the matrix transform engine, bound to the top level.
// Depends on matrix_transform_engine_defines.svh.
`include "matrix_transform_engine_defines.svh"
module mte_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_saturated
);
    `MTE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_saturated))
    `MTE_ASSERT_IMPL(a_flags_known, 1'b1, !$isunknown({o_valid, o_ready}))
    `MTE_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready)
endmodule

bind matrix_transform_engine mte_checker u_mte_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_saturated(o_saturated)
);
